>>> sv/sync_word_frame_deframer_assert.svh
// Assertion macros used by the checker of this block.
`ifndef SYNC_WORD_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_WORD_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define SWFD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define SWFD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/swfd_pkg.sv
package swfd_pkg;

  localparam int unsigned CHECK_W = 16;
  localparam int unsigned MAXLEN_W = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned OUT_DATA_W = 160;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [CHECK_W-1:0] CHECK_TARGET_RST = 16'h5A5C;
  localparam logic [MAXLEN_W-1:0] MAX_LEN_RST = 12'd1500;

  localparam logic [7:0] SYNC_BYTE = 8'hFE;
  localparam logic [15:0] SYNC_WORD = 16'hFEFE;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd12;
  localparam logic [7:0] PREVIEW_TYPE = 8'h12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  // byte offsets inside a frame
  localparam logic [IDX_W-1:0] IDX_BODY_START = 12'd4;
  localparam logic [IDX_W-1:0] IDX_VER_LO = 12'd4;
  localparam logic [IDX_W-1:0] IDX_VER_HI = 12'd5;
  localparam logic [IDX_W-1:0] IDX_SEQ = 12'd6;
  localparam logic [IDX_W-1:0] IDX_SRC = 12'd7;
  localparam logic [IDX_W-1:0] IDX_DST = 12'd8;
  localparam logic [IDX_W-1:0] IDX_TYPE = 12'd9;
  localparam logic [IDX_W-4:0] IDX_OFFSET_BLK = 9'd4;  // bytes 32..39
  localparam logic [IDX_W-3:0] IDX_COUNT_BLK = 10'd10; // bytes 40..43

  typedef struct packed {
    logic [31:0] sample_count;
    logic [63:0] sample_offset;
    logic        is_preview;
    logic [7:0]  message_type;
    logic [7:0]  dest_addr;
    logic [7:0]  source_addr;
    logic [7:0]  sequence_num;
    logic [15:0] proto_version;
    logic [15:0] frame_length;
    logic [1:0]  status;
  } result_t;

endpackage

>>> sv/sync_word_frame_deframer.sv
// Channel   Direction  Handshake                Payload
// -------   ---------  ---------                -------
// s_axis    in         s_tvalid / s_tready      one received byte
// m_axis    out        m_tvalid / m_tready      one result per frame or bad length
// cfg       in         cfg_valid / cfg_ready    register index + write data
//
// One byte per cycle while the master side keeps up: a byte is registered, goes
// through the frame update once the result slot is free and its result (if any)
// lands in the output register.
// Reset (rst, synchronous) puts the deframer in hunting with empty state and
// loads the register defaults. A result waiting on a stalled master side freezes
// the byte stage, and s_tready drops once that stage is full; cfg_ready is always high.
module sync_word_frame_deframer (
  input  logic                             clk,
  input  logic                             rst,
  // slave side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // data_byte
  // master side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // frame_length[15:0] proto_version[31:16] sequence_num[39:32]
  // source_addr[47:40] dest_addr[55:48] message_type[63:56]
  // sample_offset[127:64] sample_count[159:128]
  output logic [swfd_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [swfd_pkg::OUT_USER_W-1:0]  m_tuser,  // status[1:0] is_preview[2]
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [swfd_pkg::CHECK_W-1:0]  check_target;
  logic [swfd_pkg::MAXLEN_W-1:0] max_frame_len;

  logic              res_valid;
  logic              slot_free;
  swfd_pkg::result_t res;
  swfd_pkg::result_t out_res;

  // Register bank; writes are only legal while idle, so no interlock.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_target <= swfd_pkg::CHECK_TARGET_RST;
      max_frame_len <= swfd_pkg::MAX_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        swfd_pkg::REG_CHECK_TARGET: check_target <= cfg_data[swfd_pkg::CHECK_W-1:0];
        swfd_pkg::REG_MAX_LEN:      max_frame_len <= cfg_data[swfd_pkg::MAXLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hunt, length check, header capture and XOR check.
  swfd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_byte       (s_tdata),
    .check_target  (check_target),
    .max_frame_len (max_frame_len),
    .slot_free     (slot_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Result register; it frees itself in the same cycle it is taken.
  swfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.sample_count, out_res.sample_offset, out_res.message_type,
                    out_res.dest_addr, out_res.source_addr, out_res.sequence_num,
                    out_res.proto_version, out_res.frame_length};
  assign m_tuser = {out_res.is_preview, out_res.status};

endmodule

>>> sv/swfd_core.sv
// Input register, frame state and the per-byte update.
module swfd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic [swfd_pkg::CHECK_W-1:0]  check_target,
  input  logic [swfd_pkg::MAXLEN_W-1:0] max_frame_len,
  input  logic                          slot_free,
  output logic                          res_valid,
  output swfd_pkg::result_t             res
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LENHI = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       adv;

  phase_t phase, phase_next;
  logic [7:0] prev_a, prev_a_next, prev_b, prev_b_next;
  logic [swfd_pkg::IDX_W-1:0] byte_index, byte_index_next;
  logic [15:0] length_held, length_held_next;
  logic [15:0] xor_accum, xor_accum_next;
  logic [7:0] low_half, low_half_next;
  logic [15:0] version_held, version_held_next;
  logic [7:0] seq_held, seq_held_next, src_held, src_held_next;
  logic [7:0] dst_held, dst_held_next, type_held, type_held_next;
  logic [63:0] offset_held, offset_held_next;
  logic [31:0] count_held, count_held_next;

  logic [15:0] len_word;
  logic [16:0] idx_plus1;
  logic        preview;

  assign adv = stage_valid && slot_free;
  assign in_ready = !stage_valid || slot_free;
  assign len_word = {stage_byte, low_half};
  assign idx_plus1 = {5'd0, byte_index} + 17'd1;
  assign preview = (type_held_next == swfd_pkg::PREVIEW_TYPE);

  always_comb begin
    phase_next = phase;
    prev_a_next = prev_a;
    prev_b_next = prev_b;
    byte_index_next = byte_index;
    length_held_next = length_held;
    xor_accum_next = xor_accum;
    low_half_next = low_half;
    version_held_next = version_held;
    seq_held_next = seq_held;
    src_held_next = src_held;
    dst_held_next = dst_held;
    type_held_next = type_held;
    offset_held_next = offset_held;
    count_held_next = count_held;
    res_valid = 1'b0;
    res = '0;

    case (phase)
      PH_LENHI: begin
        xor_accum_next = xor_accum ^ len_word;
        length_held_next = len_word;
        if (len_word < swfd_pkg::MIN_FRAME_LEN ||
            len_word > {{(16-swfd_pkg::MAXLEN_W){1'b0}}, max_frame_len}) begin
          res_valid = 1'b1;
          res.status = swfd_pkg::ST_BAD_LEN;
          res.frame_length = len_word;
          phase_next = PH_HUNT;
          prev_a_next = '0;
          prev_b_next = '0;
        end else begin
          phase_next = PH_BODY;
          byte_index_next = swfd_pkg::IDX_BODY_START;
        end
      end
      PH_BODY: begin
        if (!byte_index[0]) begin
          low_half_next = stage_byte;
        end else begin
          xor_accum_next = xor_accum ^ {stage_byte, low_half};
        end
        if (byte_index == swfd_pkg::IDX_VER_LO) begin
          version_held_next[7:0] = stage_byte;
        end else if (byte_index == swfd_pkg::IDX_VER_HI) begin
          version_held_next[15:8] = stage_byte;
        end else if (byte_index == swfd_pkg::IDX_SEQ) begin
          seq_held_next = stage_byte;
        end else if (byte_index == swfd_pkg::IDX_SRC) begin
          src_held_next = stage_byte;
        end else if (byte_index == swfd_pkg::IDX_DST) begin
          dst_held_next = stage_byte;
        end else if (byte_index == swfd_pkg::IDX_TYPE) begin
          type_held_next = stage_byte;
        end else if (byte_index[swfd_pkg::IDX_W-1:3] == swfd_pkg::IDX_OFFSET_BLK) begin
          offset_held_next[{byte_index[2:0], 3'b000} +: 8] = stage_byte;
        end else if (byte_index[swfd_pkg::IDX_W-1:2] == swfd_pkg::IDX_COUNT_BLK) begin
          count_held_next[{byte_index[1:0], 3'b000} +: 8] = stage_byte;
        end

        if (idx_plus1 >= {1'b0, length_held}) begin
          res_valid = 1'b1;
          res.status = (xor_accum_next == check_target) ? swfd_pkg::ST_OK
                                                        : swfd_pkg::ST_MISMATCH;
          res.frame_length = length_held;
          res.proto_version = version_held_next;
          res.sequence_num = seq_held_next;
          res.source_addr = src_held_next;
          res.dest_addr = dst_held_next;
          res.message_type = type_held_next;
          res.is_preview = preview;
          res.sample_offset = preview ? offset_held_next : 64'd0;
          res.sample_count = preview ? count_held_next : 32'd0;
          phase_next = PH_HUNT;
          prev_a_next = '0;
          prev_b_next = '0;
        end else begin
          byte_index_next = idx_plus1[swfd_pkg::IDX_W-1:0];
        end
      end
      default: begin
        if (prev_a == swfd_pkg::SYNC_BYTE && prev_b == swfd_pkg::SYNC_BYTE &&
            stage_byte != swfd_pkg::SYNC_BYTE) begin
          // new frame: clear everything held from the last one
          byte_index_next = '0;
          length_held_next = '0;
          xor_accum_next = swfd_pkg::SYNC_WORD;
          low_half_next = stage_byte;
          version_held_next = '0;
          seq_held_next = '0;
          src_held_next = '0;
          dst_held_next = '0;
          type_held_next = '0;
          offset_held_next = '0;
          count_held_next = '0;
          phase_next = PH_LENHI;
        end else begin
          phase_next = PH_HUNT;
          prev_a_next = prev_b;
          prev_b_next = stage_byte;
        end
      end
    endcase

    if (!adv) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      phase <= PH_HUNT;
      prev_a <= '0;
      prev_b <= '0;
      byte_index <= '0;
      length_held <= '0;
      xor_accum <= '0;
      low_half <= '0;
      version_held <= '0;
      seq_held <= '0;
      src_held <= '0;
      dst_held <= '0;
      type_held <= '0;
      offset_held <= '0;
      count_held <= '0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (adv) begin
        phase <= phase_next;
        prev_a <= prev_a_next;
        prev_b <= prev_b_next;
        byte_index <= byte_index_next;
        length_held <= length_held_next;
        xor_accum <= xor_accum_next;
        low_half <= low_half_next;
        version_held <= version_held_next;
        seq_held <= seq_held_next;
        src_held <= src_held_next;
        dst_held <= dst_held_next;
        type_held <= type_held_next;
        offset_held <= offset_held_next;
        count_held <= count_held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_byte <= in_byte;
    end
  end

endmodule

>>> sv/swfd_out_reg.sv
// Result register on the master side.
module swfd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  swfd_pkg::result_t res,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output swfd_pkg::result_t out_res
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> sv/swfd_checker.sv
`include "sync_word_frame_deframer_assert.svh"

module swfd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [swfd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [swfd_pkg::OUT_USER_W-1:0] m_tuser
);

  `SWFD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `SWFD_ASSERT_IMPL(a_status_code, clk, rst, m_tvalid, m_tuser[1:0] != 2'd3, "undefined status code")
  `SWFD_ASSERT_IMPL(a_bad_len_clean, clk, rst, m_tvalid && m_tuser[1:0] == swfd_pkg::ST_BAD_LEN, m_tdata[159:16] == '0 && !m_tuser[2], "bad length result carries header fields")
  `SWFD_ASSERT_IMPL(a_preview_type, clk, rst, m_tvalid && m_tuser[2], m_tdata[63:56] == swfd_pkg::PREVIEW_TYPE, "preview flag without preview type")
  `SWFD_ASSERT_IMPL(a_no_preview_zero, clk, rst, m_tvalid && !m_tuser[2], m_tdata[159:64] == '0, "sample fields set on non-preview frame")

endmodule

bind sync_word_frame_deframer swfd_checker u_swfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/sync_word_frame_deframer_tb.sv
module sync_word_frame_deframer_tb;
  import swfd_pkg::*;

  // Run ceiling in clock cycles; the slowest correct run is far below this.
  localparam int CYCLE_LIMIT = 800000;
  // Cycles to let the byte and result stages empty out before a register write.
  localparam int SETTLE_CYCLES = 4;

  // Deframer phases as tracked by the local model.
  typedef enum logic [1:0] {
    PH_HUNTING,
    PH_LEN_HIGH,
    PH_IN_FRAME
  } deframe_phase_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sync_word_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 unit period clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the deframer: registers and frame state
  // ---------------------------------------------------------------------------
  logic [CHECK_W-1:0]  cfg_target;
  logic [MAXLEN_W-1:0] cfg_max_len;

  deframe_phase_t phase_q;
  logic [7:0]     win_old;     // older byte of the hunt window
  logic [7:0]     win_new;     // newer byte of the hunt window
  logic [IDX_W-1:0] byte_pos;  // frame offset of the next byte
  logic [15:0]    len_q;
  logic [15:0]    xor_q;
  logic [7:0]     lo_q;        // low byte of the word being assembled
  logic [15:0]    ver_q;
  logic [7:0]     seq_q, src_q, dst_q, type_q;
  logic [63:0]    ofs_q;
  logic [31:0]    cnt_q;

  result_t expected_reports[$];

  // Idle knobs, in percent of cycles
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  // Bookkeeping
  int errors = 0;
  int bytes_sent = 0;
  int reports_seen = 0;
  int ok_frames = 0;
  int bad_check_frames = 0;
  int bad_len_frames = 0;
  int cycle_count = 0;

  function automatic void restart_hunt();
    phase_q = PH_HUNTING;
    win_old = '0;
    win_new = '0;
  endfunction

  function automatic void clear_frame_state();
    byte_pos = '0;
    len_q    = '0;
    xor_q    = '0;
    lo_q     = '0;
    ver_q    = '0;
    seq_q    = '0;
    src_q    = '0;
    dst_q    = '0;
    type_q   = '0;
    ofs_q    = '0;
    cnt_q    = '0;
  endfunction

  function automatic void model_reset();
    cfg_target  = CHECK_TARGET_RST;
    cfg_max_len = MAX_LEN_RST;
    restart_hunt();
    clear_frame_state();
  endfunction

  // Advance the model by one accepted byte; queue the report it causes, if any.
  function automatic void deframe_byte(input logic [7:0] b);
    result_t     r;
    logic [15:0] word;
    logic        preview;
    r = '0;
    case (phase_q)
      PH_LEN_HIGH: begin
        word  = {b, lo_q};
        xor_q = xor_q ^ word;
        len_q = word;
        if (word < MIN_FRAME_LEN || word > {4'd0, cfg_max_len}) begin
          // bad length: only the received length goes out with the status
          r.status       = ST_BAD_LEN;
          r.frame_length = word;
          expected_reports.push_back(r);
          restart_hunt();
        end else begin
          phase_q  = PH_IN_FRAME;
          byte_pos = IDX_BODY_START;
        end
      end
      PH_IN_FRAME: begin
        if (!byte_pos[0]) lo_q = b;
        else xor_q = xor_q ^ {b, lo_q};

        if (byte_pos == IDX_VER_LO) ver_q[7:0] = b;
        else if (byte_pos == IDX_VER_HI) ver_q[15:8] = b;
        else if (byte_pos == IDX_SEQ) seq_q = b;
        else if (byte_pos == IDX_SRC) src_q = b;
        else if (byte_pos == IDX_DST) dst_q = b;
        else if (byte_pos == IDX_TYPE) type_q = b;
        else if (byte_pos[IDX_W-1:3] == IDX_OFFSET_BLK) ofs_q[byte_pos[2:0]*8 +: 8] = b;
        else if (byte_pos[IDX_W-1:2] == IDX_COUNT_BLK) cnt_q[byte_pos[1:0]*8 +: 8] = b;

        if (({5'd0, byte_pos} + 17'd1) >= {1'b0, len_q}) begin
          preview         = (type_q == PREVIEW_TYPE);
          r.status        = (xor_q == cfg_target) ? ST_OK : ST_MISMATCH;
          r.frame_length  = len_q;
          r.proto_version = ver_q;
          r.sequence_num  = seq_q;
          r.source_addr   = src_q;
          r.dest_addr     = dst_q;
          r.message_type  = type_q;
          r.is_preview    = preview;
          r.sample_offset = preview ? ofs_q : '0;
          r.sample_count  = preview ? cnt_q : '0;
          expected_reports.push_back(r);
          restart_hunt();
        end else begin
          byte_pos = byte_pos + 1'b1;
        end
      end
      default: begin
        if (win_old == SYNC_BYTE && win_new == SYNC_BYTE && b != SYNC_BYTE) begin
          clear_frame_state();
          xor_q   = SYNC_WORD;
          lo_q    = b;
          phase_q = PH_LEN_HIGH;
        end else begin
          phase_q = PH_HUNTING;
          win_old = win_new;
          win_new = b;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls and the report checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) m_tready <= ($urandom_range(99) >= snk_stall_pct);

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  result_t want_rpt;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("report with nothing expected: tdata %0h tuser %0h", m_tdata, m_tuser);
        errors++;
      end else begin
        want_rpt = expected_reports.pop_front();
        case (want_rpt.status)
          ST_OK:       ok_frames++;
          ST_MISMATCH: bad_check_frames++;
          default:     bad_len_frames++;
        endcase
        check_field("status",        want_rpt.status,        m_tuser[1:0]);
        check_field("is_preview",    want_rpt.is_preview,    m_tuser[2]);
        check_field("frame_length",  want_rpt.frame_length,  m_tdata[15:0]);
        check_field("proto_version", want_rpt.proto_version, m_tdata[31:16]);
        check_field("sequence_num",  want_rpt.sequence_num,  m_tdata[39:32]);
        check_field("source_addr",   want_rpt.source_addr,   m_tdata[47:40]);
        check_field("dest_addr",     want_rpt.dest_addr,     m_tdata[55:48]);
        check_field("message_type",  want_rpt.message_type,  m_tdata[63:56]);
        check_field("sample_offset", want_rpt.sample_offset, m_tdata[127:64]);
        check_field("sample_count",  want_rpt.sample_count,  m_tdata[159:128]);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Entered and left at a falling edge. Random gaps before the byte is offered.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every report is back and the pipeline has emptied.
  task automatic drain_reports();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle (after drain_reports).
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CHECK_TARGET) cfg_target = val;
    else cfg_max_len = val[MAXLEN_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_max_len(input int n);
    write_reg(REG_MAX_LEN, {4'($urandom), 12'(n)});
  endtask

  // Sync word plus length only; for lengths that are to be rejected.
  task automatic send_header(input logic [15:0] len);
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
  endtask

  // Build a frame of len (>= 12) bytes with random content, a check word that
  // hits or misses the current target, and send its first cut bytes.
  // tail_fe forces the last two bytes to the sync value (len >= 14).
  task automatic send_frame(input int len, input logic [7:0] kind, input bit good,
                            input int cut, input bit tail_fe);
    logic [7:0]  fb[];
    logic [15:0] acc;
    logic [15:0] w;
    int          k;
    fb = new[len];
    foreach (fb[j]) fb[j] = 8'($urandom);
    fb[0] = SYNC_BYTE;
    fb[1] = SYNC_BYTE;
    fb[2] = len[7:0];
    fb[3] = len[15:8];
    fb[IDX_TYPE] = kind;
    if (tail_fe) begin
      fb[len-2] = SYNC_BYTE;
      fb[len-1] = SYNC_BYTE;
    end
    fb[10] = '0;
    fb[11] = '0;
    acc = '0;
    for (k = 0; k + 1 < len; k += 2) acc = acc ^ {fb[k+1], fb[k]};
    w = acc ^ cfg_target;
    if (!good) w = w ^ 16'($urandom_range(1, 65535));
    fb[10] = w[7:0];
    fb[11] = w[15:8];
    for (k = 0; k < cut; k++) push_byte(fb[k]);
  endtask

  function automatic logic [7:0] pick_kind();
    return ($urandom_range(99) < 30) ? PREVIEW_TYPE : 8'($urandom);
  endfunction

  // Mostly short frames, some up to 200 bytes, now and then exactly the maximum (if at most 300).
  function automatic int pick_frame_len();
    int hi;
    int r;
    int n;
    hi = (cfg_max_len < 200) ? int'(cfg_max_len) : 200;
    r  = $urandom_range(99);
    if (r < 70) n = $urandom_range(12, (hi < 47) ? hi : 47);
    else if (r < 95) n = $urandom_range(12, hi);
    else n = (cfg_max_len <= 300) ? int'(cfg_max_len) : hi;
    // a length low byte equal to the sync value would extend the hunt
    if (n[7:0] == SYNC_BYTE) n = n - 1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values, field extremes, every status and the corner cases.
  task automatic test_directed_cases();
    send_frame(12, 8'h00, 1'b1, 12, 1'b0);          // shortest legal frame, check hit
    send_frame(13, 8'hFF, 1'b0, 13, 1'b0);          // odd length, check miss
    send_frame(20, PREVIEW_TYPE, 1'b1, 20, 1'b0);   // preview cut before sample fields
    send_frame(44, PREVIEW_TYPE, 1'b1, 44, 1'b0);   // preview with all sample fields
    send_header(16'd11);                            // one below the minimum
    send_header(16'd1501);                          // one above the reset maximum
    send_header(16'h0000);
    send_header(16'hFFFF);
    // triple sync byte: the hunt slides on by one
    push_byte(SYNC_BYTE);
    send_frame(12, 8'h5A, 1'b1, 12, 1'b0);
    // frame ending in two sync bytes must not seed a new hunt
    send_frame(14, 8'h01, 1'b1, 14, 1'b1);
    push_byte(8'h20);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    drain_reports();
  endtask

  // Register extremes, each with frames that probe the new setting.
  task automatic test_register_extremes();
    set_max_len(0);                                 // every length rejected
    send_frame(12, 8'h00, 1'b1, 12, 1'b0);
    drain_reports();
    set_max_len(11);
    send_header(16'd11);
    send_header(16'd12);
    drain_reports();
    set_max_len(12);                                // only twelve-byte frames pass
    write_reg(REG_CHECK_TARGET, 16'h0000);
    send_frame(12, PREVIEW_TYPE, 1'b1, 12, 1'b0);
    send_header(16'd13);
    drain_reports();
    write_reg(REG_CHECK_TARGET, 16'hFFFF);
    set_max_len(4095);                              // widest maximum
    send_frame(260, PREVIEW_TYPE, 1'b1, 260, 1'b0);
    send_header(16'd4096);
    send_frame(30, 8'h33, 1'b0, 30, 1'b0);
    drain_reports();
  endtask

  // Mixed traffic, mostly well-formed frames, until quota bytes have gone in.
  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int quota);
    int start;
    int r;
    int len;
    int n;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      r = $urandom_range(99);
      if (r < 65) begin
        len = pick_frame_len();
        send_frame(len, pick_kind(), ($urandom_range(99) < 70), len, 1'b0);
      end else if (r < 75) begin
        if ($urandom_range(1)) send_header(16'($urandom_range(0, 11)));
        else send_header(16'($urandom_range(int'(cfg_max_len) + 1, 65535)));
      end else if (r < 85) begin
        // frame broken off early; what follows lands in its body
        len = $urandom_range(14, 47);
        send_frame(len, pick_kind(), 1'b1, $urandom_range(1, len - 1), 1'b0);
      end else if (r < 98) begin
        n = $urandom_range(1, 8);
        repeat (n) push_byte(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
      end else begin
        drain_reports();                            // sender holds off until all is back
      end
    end
    drain_reports();
  endtask

  initial begin
    model_reset();
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_register_extremes();

    write_reg(REG_CHECK_TARGET, 16'($urandom));
    set_max_len($urandom_range(44, 300));
    test_random_traffic(6, 79, 480);

    write_reg(REG_CHECK_TARGET, 16'($urandom));
    set_max_len(4095);
    test_random_traffic(79, 6, 480);

    write_reg(REG_CHECK_TARGET, 16'hFFFF);
    set_max_len(1500);
    test_random_traffic(0, 0, 480);

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    drain_reports();
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes over directed, register-extreme and three idle-pattern phases.",
             bytes_sent);
    $display("Checked %0d reports: %0d good frames, %0d check misses, %0d bad lengths.",
             reports_seen, ok_frames, bad_check_frames, bad_len_frames);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/swfd_pkg.sv
sv/swfd_core.sv
sv/swfd_out_reg.sv
sv/sync_word_frame_deframer.sv
sv/swfd_checker.sv
dv/sync_word_frame_deframer_tb.sv
